// File: hdl/sfr_pkg.sv
// Shared types and constants for the SPI fast-read master.
// Used by sfr_core, sfr_out_reg and spi_fast_read_master; no dependencies.
package sfr_pkg;

    // Header length: command, three address bytes, dummy byte
    localparam logic [5:0] HEADER_BITS = 6'd40;
    localparam logic [7:0] DUMMY_BYTE  = 8'hAA;
    localparam logic [2:0] LAST_BIT    = 3'd7;

    // One bit period presented to the engine
    typedef struct packed {
        logic        start_req;
        logic [7:0]  command;
        logic [23:0] address;
        logic [7:0]  length;
        logic        serial_in;
    } item_t;

    // Line activity and receive status for one bit period
    typedef struct packed {
        logic        chip_select_n;
        logic        serial_out;
        logic        clock_pulse;
        logic [7:0]  read_byte;
        logic        byte_valid;
        logic        done_res;
    } result_t;

endpackage

// File: hdl/sfr_core.sv
// Transfer engine of the SPI fast-read master: header shifter, byte receiver.
// Depends on sfr_pkg for item_t, result_t and header constants.
module sfr_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_accept,
    input  sfr_pkg::item_t  item,
    output sfr_pkg::result_t result
);

    logic        busy_reg, busy_next;
    logic [39:0] header_shift_reg, header_shift_next;
    logic [5:0]  header_bits_left_reg, header_bits_left_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  receive_shift_reg, receive_shift_next;
    logic [7:0]  rx_shifted;

    assign rx_shifted = {receive_shift_reg[6:0], item.serial_in};

    // Step logic: one bit period per accepted transaction
    always_comb begin
        busy_next             = busy_reg;
        header_shift_next     = header_shift_reg;
        header_bits_left_next = header_bits_left_reg;
        bytes_left_next       = bytes_left_reg;
        bit_index_next        = bit_index_reg;
        receive_shift_next    = receive_shift_reg;
        result                = '0;
        result.chip_select_n  = 1'b1;

        if (!busy_reg) begin
            if (item.start_req) begin
                busy_next             = 1'b1;
                header_shift_next     = {item.command, item.address, sfr_pkg::DUMMY_BYTE};
                header_bits_left_next = sfr_pkg::HEADER_BITS;
                bytes_left_next       = item.length;
                bit_index_next        = '0;
                receive_shift_next    = '0;
                result.chip_select_n  = 1'b0;
            end
        end else if (header_bits_left_reg != '0) begin
            // Shift out header, MSB first
            result.chip_select_n  = 1'b0;
            result.clock_pulse    = 1'b1;
            result.serial_out     = header_shift_reg[39];
            header_shift_next     = {header_shift_reg[38:0], 1'b0};
            header_bits_left_next = header_bits_left_reg - 6'd1;
        end else if (bytes_left_reg != '0) begin
            // Sample data, report on the eighth bit
            result.chip_select_n = 1'b0;
            result.clock_pulse   = 1'b1;
            if (bit_index_reg == sfr_pkg::LAST_BIT) begin
                result.read_byte   = rx_shifted;
                result.byte_valid  = 1'b1;
                bit_index_next     = '0;
                receive_shift_next = '0;
                bytes_left_next    = bytes_left_reg - 8'd1;
            end else begin
                bit_index_next     = bit_index_reg + 3'd1;
                receive_shift_next = rx_shifted;
            end
        end else begin
            // Release select
            busy_next          = 1'b0;
            bit_index_next     = '0;
            receive_shift_next = '0;
            result.done_res    = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg             <= 1'b0;
            header_shift_reg     <= '0;
            header_bits_left_reg <= '0;
            bytes_left_reg       <= '0;
            bit_index_reg        <= '0;
            receive_shift_reg    <= '0;
        end else if (item_accept) begin
            busy_reg             <= busy_next;
            header_shift_reg     <= header_shift_next;
            header_bits_left_reg <= header_bits_left_next;
            bytes_left_reg       <= bytes_left_next;
            bit_index_reg        <= bit_index_next;
            receive_shift_reg    <= receive_shift_next;
        end
    end

`ifndef SYNTHESIS
    a_header_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        header_bits_left_reg != '0 |-> busy_reg)
        else $error("header bits pending while idle");
    a_idle_rx_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (bit_index_reg == '0 && receive_shift_reg == '0))
        else $error("receiver not cleared while idle");
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && result.done_res |=> !busy_reg)
        else $error("engine still busy after done");
    a_byte_needs_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        result.byte_valid |-> (result.clock_pulse && !result.chip_select_n))
        else $error("byte reported without a clocked read period");
`endif

endmodule

// File: hdl/sfr_out_reg.sv
// Result register with pass-through ready for the SPI fast-read master.
// Depends on sfr_pkg for result_t.
module sfr_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  sfr_pkg::result_t result,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sfr_pkg::result_t out_data
);

    logic             valid_reg, valid_next;
    sfr_pkg::result_t data_reg;

    // Free when empty or when the held transaction leaves this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/spi_fast_read_master.sv
// SPI flash fast-read master: one stream transaction in is one serial bit period
// out; sends command, address and dummy byte, then reads length bytes. One
// transaction per clock is sustained: the step logic sits between the input
// handshake and a single result register, so the only limit is the result
// register draining (m_tready). Each input transaction yields exactly one result.
// Depends on sfr_pkg, sfr_core and sfr_out_reg.
module spi_fast_read_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[7:0], address[31:8], length[39:32],
                                   // serial_in[40], zero[47:41]
    input  logic        s_tuser,   // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // chip_select_n[0], serial_out[1],
                                   // clock_pulse[2], read_byte[10:3], zero[15:11]
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast    // done_res
);

    logic             accept;
    sfr_pkg::item_t   item;
    sfr_pkg::result_t step_res;
    sfr_pkg::result_t out_res;

    assign accept = s_tvalid && s_tready;

    // Unpack input transaction
    always_comb begin
        item.start_req = s_tuser;
        item.command   = s_tdata[7:0];
        item.address   = s_tdata[31:8];
        item.length    = s_tdata[39:32];
        item.serial_in = s_tdata[40];
    end

    sfr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (accept),
        .item        (item),
        .result      (step_res)
    );

    sfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .result    (step_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack result transaction
    assign m_tdata = {5'b0, out_res.read_byte, out_res.clock_pulse,
                      out_res.serial_out, out_res.chip_select_n};
    assign m_tuser = out_res.byte_valid;
    assign m_tlast = out_res.done_res;

endmodule
